// ----- rtl/core/ddo_pkg.sv -----
package ddo_pkg;

    localparam int POSITION_BITS_DEF = 48;
    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] TURN_GAIN_RESET = 32'h0100_0000;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic [23:0]        elapsed_time;
    } in_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [31:0]        heading_out;
        logic signed [31:0] linear_speed;
        logic signed [31:0] turn_rate;
    } out_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/diff_drive_odometry.sv -----
// Channel   Direction  Payload            Transaction
// in        input      ddo_pkg::in_t      in_valid && in_ready
// out       output     ddo_pkg::out_t     out_valid && out_ready
// cfg       input      turn_gain, 32 bit  cfg_valid && cfg_ready
//
// Each item is accepted, then passes the bit-serial products with the elapsed
// time (the CORDIC runs beside them), a prepare step, the bit-serial products
// with the gain, cosine and sine, and the pose update, stalled by a full output.
// One item is worked on at a time; a new one is taken once the pose is updated,
// even while the previous result still waits in the output register.
// Reset clears the pose to zero and the gain to one turn per meter.
module diff_drive_odometry #(
    parameter int POSITION_BITS = ddo_pkg::POSITION_BITS_DEF,
    parameter int TRIG_ITERATIONS = ddo_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ddo_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ddo_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);

    localparam int PW = POSITION_BITS;
    localparam int SW = ((PW > 40) ? PW : 40) + 1;
    localparam int NIT = (TRIG_ITERATIONS > ddo_pkg::ATAN_ENTRIES) ?
                         ddo_pkg::ATAN_ENTRIES : TRIG_ITERATIONS;
    localparam logic [4:0] NIT_C = 5'(NIT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic signed [SW-1:0] PMAX = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [SW-1:0] PMIN = ~PMAX;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg;
    logic [31:0] gain_reg;
    logic signed [PW-1:0] x_reg, y_reg;
    logic [31:0] head_reg;
    logic out_valid_reg;
    ddo_pkg::out_t out_reg;

    logic [23:0] t_sh_reg;
    logic signed [56:0] sum_sh_reg, diff_sh_reg, acc_a_reg, acc_dt_reg;
    logic signed [32:0] sum_reg, diff_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;

    logic [31:0] gain_sh_reg, cm_reg, sm_reg;
    logic [59:0] dt_sh_reg, dacc_reg;
    logic [63:0] mag_sh_reg, racc_reg;
    logic [88:0] ma_sh_reg, xacc_reg, yacc_reg;
    logic negx_reg, negy_reg;

    logic signed [32:0] sum_in, diff_in;
    logic signed [33:0] xs, ys, cos_v, sin_v, cos_abs, sin_abs;
    logic signed [32:0] atan_v;
    logic signed [56:0] a_abs;
    logic [32:0] diff_mag;
    logic signed [SW-1:0] dx, dy, sx, sy;
    logic signed [PW-1:0] x_next, y_next;
    logic [47:0] rmag;
    logic [31:0] rate_v;
    logic signed [63:0] xe, ye;
    logic fin_go;

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    assign sum_in = {in_data.left_speed[31], in_data.left_speed}
                  + {in_data.right_speed[31], in_data.right_speed};
    assign diff_in = {in_data.right_speed[31], in_data.right_speed}
                   - {in_data.left_speed[31], in_data.left_speed};

    assign xs = cx_reg >>> cnt_reg;
    assign ys = cy_reg >>> cnt_reg;
    assign atan_v = signed'({1'b0, ddo_pkg::atan_entry(cnt_reg)});

    always_comb
    begin
        case (head_reg[31:30])
            2'd0:    begin cos_v = cx_reg;  sin_v = cy_reg;  end
            2'd1:    begin cos_v = -cy_reg; sin_v = cx_reg;  end
            2'd2:    begin cos_v = -cx_reg; sin_v = -cy_reg; end
            default: begin cos_v = cy_reg;  sin_v = -cx_reg; end
        endcase
    end

    assign cos_abs = cos_v[33] ? -cos_v : cos_v;
    assign sin_abs = sin_v[33] ? -sin_v : sin_v;
    assign a_abs = acc_a_reg[56] ? -acc_a_reg : acc_a_reg;
    assign diff_mag = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);

    assign dx = negx_reg ? -SW'(signed'({1'b0, xacc_reg[88:51]}))
                         : SW'(signed'({1'b0, xacc_reg[88:51]}));
    assign dy = negy_reg ? -SW'(signed'({1'b0, yacc_reg[88:51]}))
                         : SW'(signed'({1'b0, yacc_reg[88:51]}));
    assign sx = SW'(x_reg) + dx;
    assign sy = SW'(y_reg) + dy;
    assign x_next = (sx > PMAX) ? PMAX[PW-1:0] : (sx < PMIN) ? PMIN[PW-1:0] : sx[PW-1:0];
    assign y_next = (sy > PMAX) ? PMAX[PW-1:0] : (sy < PMIN) ? PMIN[PW-1:0] : sy[PW-1:0];
    assign xe = 64'(x_next);
    assign ye = 64'(y_next);

    assign rmag = racc_reg[63:16];
    always_comb
    begin
        if (!diff_reg[32])
            rate_v = (rmag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : rmag[31:0];
        else
            rate_v = (rmag > 48'h8000_0000) ? 32'h8000_0000 : -rmag[31:0];
    end

    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_MUL1;
            S_MUL1: if (cnt_reg == 5'd23) state_next = S_PREP;
            S_PREP: state_next = S_MUL2;
            S_MUL2: if (cnt_reg == 5'd31) state_next = S_FIN;
            S_FIN:  if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= 5'd0;
            gain_reg <= ddo_pkg::TURN_GAIN_RESET;
            x_reg <= '0;
            y_reg <= '0;
            head_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                gain_reg <= cfg_data;
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= 5'd0;
                    if (in_valid)
                    begin
                        t_sh_reg <= in_data.elapsed_time;
                        sum_reg <= sum_in;
                        diff_reg <= diff_in;
                        sum_sh_reg <= 57'(sum_in);
                        diff_sh_reg <= 57'(diff_in);
                        acc_a_reg <= '0;
                        acc_dt_reg <= '0;
                        cx_reg <= ddo_pkg::CORDIC_K;
                        cy_reg <= '0;
                        cz_reg <= signed'({3'b000, head_reg[29:0]});
                    end
                end
                S_MUL1:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (t_sh_reg[0])
                    begin
                        acc_a_reg <= acc_a_reg + sum_sh_reg;
                        acc_dt_reg <= acc_dt_reg + diff_sh_reg;
                    end
                    t_sh_reg <= t_sh_reg >> 1;
                    sum_sh_reg <= sum_sh_reg <<< 1;
                    diff_sh_reg <= diff_sh_reg <<< 1;
                    if (cnt_reg < NIT_C)
                    begin
                        if (!cz_reg[32])
                        begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - atan_v;
                        end
                        else
                        begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + atan_v;
                        end
                    end
                end
                S_PREP:
                begin
                    cnt_reg <= 5'd0;
                    gain_sh_reg <= gain_reg;
                    dt_sh_reg <= 60'(acc_dt_reg);
                    mag_sh_reg <= 64'(diff_mag);
                    ma_sh_reg <= 89'(unsigned'(a_abs));
                    cm_reg <= cos_abs[31:0];
                    sm_reg <= sin_abs[31:0];
                    negx_reg <= acc_a_reg[56] ^ cos_v[33];
                    negy_reg <= acc_a_reg[56] ^ sin_v[33];
                    dacc_reg <= '0;
                    racc_reg <= '0;
                    xacc_reg <= '0;
                    yacc_reg <= '0;
                end
                S_MUL2:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (gain_sh_reg[0])
                    begin
                        dacc_reg <= dacc_reg + dt_sh_reg;
                        racc_reg <= racc_reg + mag_sh_reg;
                    end
                    if (cm_reg[0])
                        xacc_reg <= xacc_reg + ma_sh_reg;
                    if (sm_reg[0])
                        yacc_reg <= yacc_reg + ma_sh_reg;
                    gain_sh_reg <= gain_sh_reg >> 1;
                    cm_reg <= cm_reg >> 1;
                    sm_reg <= sm_reg >> 1;
                    dt_sh_reg <= dt_sh_reg << 1;
                    mag_sh_reg <= mag_sh_reg << 1;
                    ma_sh_reg <= ma_sh_reg << 1;
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        x_reg <= x_next;
                        y_reg <= y_next;
                        head_reg <= head_reg + dacc_reg[59:28];
                        out_reg.pos_x <= xe[47:0];
                        out_reg.pos_y <= ye[47:0];
                        out_reg.heading_out <= head_reg + dacc_reg[59:28];
                        out_reg.linear_speed <= 32'(sum_reg >>> 1);
                        out_reg.turn_rate <= rate_v;
                    end
                end
                default:
                begin
                    cnt_reg <= 5'd0;
                end
            endcase
        end
    end

endmodule
